// ===== hw/rtl/apt_pkg.sv =====
package apt_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned IDX_W  = 8;

  localparam logic [WORD_W-1:0] SPEED_MAX          = 16'hFFFF;
  localparam logic [WORD_W-1:0] COUNT_MAX          = 16'hFFFF;
  localparam logic [WORD_W-1:0] THRESHOLD_RESET    = 16'd50000;
  localparam logic [WORD_W-1:0] SPEED_CONST_RESET  = 16'd40250;

  localparam logic [IDX_W-1:0] REG_SUM_THRESHOLD  = 8'd0;
  localparam logic [IDX_W-1:0] REG_SPEED_CONSTANT = 8'd1;

  localparam logic OP_EDGE     = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  localparam logic CAUSE_MEASURE = 1'b0;
  localparam logic CAUSE_REPEAT  = 1'b1;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic              repeat_req;
    logic [SUM_W-1:0]  sum;
    logic [WORD_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/averaged_period_tachometer.sv =====
// Channel  | Handshake            | Payload
// input    | push / full          | operation, period
// result   | empty / pop          | speed, cause
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Edge items that keep the sum at or below threshold leave no result.
// An overflow tick's result is registered in the job queue, then in the output register.
// A threshold crossing runs two 17-step divisions on one shared divider
// (only one when the average is zero and the second division is skipped).
// A two-entry job queue lets input flow while the divider works or a result waits.
// Reset is synchronous; cfg_ready is always high.
module averaged_period_tachometer import apt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              operation,
  input  logic [WORD_W-1:0] period,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] speed,
  output logic              cause,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  logic [WORD_W-1:0] sum_threshold;
  logic [WORD_W-1:0] speed_constant;
  logic              job_push;
  logic              job_full;
  logic              job_pop;
  logic              job_empty;
  job_t              job_in;
  job_t              job_out;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_threshold  <= THRESHOLD_RESET;
      speed_constant <= SPEED_CONST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SUM_THRESHOLD:  sum_threshold  <= cfg_data;
        REG_SPEED_CONSTANT: speed_constant <= cfg_data;
        default: ;
      endcase
    end
  end

  apt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .period    (period),
    .threshold (sum_threshold),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  apt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_en  (job_push),
    .push_job (job_in),
    .full     (job_full),
    .pop_en   (job_pop),
    .pop_job  (job_out),
    .empty    (job_empty)
  );

  apt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  apt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .speed_constant (speed_constant),
    .job_empty      (job_empty),
    .job            (job_out),
    .job_pop        (job_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .empty          (empty),
    .pop            (pop),
    .speed          (speed),
    .cause          (cause)
  );

endmodule

// ===== hw/rtl/apt_queue.sv =====
module apt_queue import apt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_en,
  input  job_t push_job,
  output logic full,
  input  logic pop_en,
  output job_t pop_job,
  output logic empty
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_en && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_en && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_en && !full, pop_en && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/apt_front.sv =====
module apt_front import apt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              operation,
  input  logic [WORD_W-1:0] period,
  input  logic [WORD_W-1:0] threshold,
  output logic              job_push,
  output job_t              job,
  input  logic              job_full
);

  logic [SUM_W-1:0]  period_sum;
  logic [WORD_W-1:0] edge_count;
  logic [SUM_W-1:0]  sum_next;
  logic [WORD_W-1:0] count_next;
  logic              accept;
  logic              crossed;

  assign full   = job_full;
  assign accept = push && !job_full;

  // Sum never exceeds a 16-bit value before an add, so 17 bits cannot wrap.
  assign sum_next   = period_sum + {1'b0, period};
  assign count_next = (edge_count == COUNT_MAX) ? edge_count : edge_count + 16'd1;
  assign crossed    = sum_next > {1'b0, threshold};

  always_comb begin
    job_push       = 1'b0;
    job.repeat_req = 1'b0;
    job.sum        = sum_next;
    job.count      = count_next;
    if (accept) begin
      if (operation == OP_OVERFLOW) begin
        job_push       = 1'b1;
        job.repeat_req = 1'b1;
      end else if (crossed) begin
        job_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_sum <= '0;
      edge_count <= '0;
    end else if (accept && operation == OP_EDGE) begin
      if (crossed) begin
        period_sum <= '0;
        edge_count <= '0;
      end else begin
        period_sum <= sum_next;
        edge_count <= count_next;
      end
    end
  end

endmodule

// ===== hw/rtl/apt_div.sv =====
module apt_div import apt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [4:0] LAST_STEP = 5'(SUM_W - 1);

  logic             busy;
  logic             done;
  logic [4:0]       step;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] dvs;
  logic [SUM_W:0]   shifted;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem, quo[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? SUM_W'(shifted - {1'b0, dvs}) : shifted[SUM_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/apt_back.sv =====
module apt_back import apt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] speed_constant,
  input  logic              job_empty,
  input  job_t              job,
  output logic              job_pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] speed,
  output logic              cause
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_AVG  = 2'd1;
  localparam logic [1:0] ST_SPD  = 2'd2;

  logic [1:0]        state;
  logic [WORD_W-1:0] last_speed;
  logic              out_valid;
  logic              take;
  logic              avg_zero;

  assign empty    = !out_valid;
  assign take     = (state == ST_IDLE) && !job_empty && !out_valid;
  assign job_pop  = take;
  assign avg_zero = (div_rsp.quotient == '0);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, speed_constant};
    div_req.divisor  = div_rsp.quotient;
    if (take && !job.repeat_req) begin
      div_req.start    = 1'b1;
      div_req.dividend = job.sum;
      div_req.divisor  = {1'b0, job.count};
    end else if (state == ST_AVG && div_rsp.done && !avg_zero) begin
      div_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && job.repeat_req) begin
      speed <= last_speed;
      cause <= CAUSE_REPEAT;
    end else if (state == ST_AVG && div_rsp.done && avg_zero) begin
      speed <= SPEED_MAX;
      cause <= CAUSE_MEASURE;
    end else if (state == ST_SPD && div_rsp.done) begin
      speed <= div_rsp.quotient[WORD_W-1:0];
      cause <= CAUSE_MEASURE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      last_speed <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (job.repeat_req) begin
              out_valid <= 1'b1;
            end else begin
              state <= ST_AVG;
            end
          end
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            if (avg_zero) begin
              last_speed <= SPEED_MAX;
              out_valid  <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              state <= ST_SPD;
            end
          end
        end
        ST_SPD: begin
          if (div_rsp.done) begin
            last_speed <= div_rsp.quotient[WORD_W-1:0];
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/speed_checker.sv =====
`timescale 1ns / 1ps

module speed_checker import apt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic              operation,
  input  logic [WORD_W-1:0] period,
  input  logic              empty,
  input  logic              pop,
  input  logic [WORD_W-1:0] speed,
  input  logic              cause,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [WORD_W-1:0] speed;
    logic              cause;
  } speed_rec_t;

  speed_rec_t        expected_speeds[$];

  logic [WORD_W-1:0] threshold;
  logic [WORD_W-1:0] speed_const;
  logic [SUM_W-1:0]  period_acc;
  logic [WORD_W-1:0] edge_cnt;
  logic [WORD_W-1:0] held_speed;

  // Advance the tachometer state by one input transaction.
  function automatic bit predict_speed(input logic op, input logic [WORD_W-1:0] per,
                                       output speed_rec_t rec);
    logic [SUM_W-1:0] avg;
    rec = '0;
    if (op == OP_OVERFLOW) begin
      rec.speed = held_speed;
      rec.cause = CAUSE_REPEAT;
      return 1'b1;
    end
    period_acc = period_acc + SUM_W'(per);
    if (edge_cnt != COUNT_MAX) edge_cnt = edge_cnt + 1'b1;
    if (period_acc <= SUM_W'(threshold)) return 1'b0;
    avg = period_acc / SUM_W'(edge_cnt);
    // more edges than the summed period truncates to zero: clamp instead of dividing
    if (avg == '0) held_speed = SPEED_MAX;
    else held_speed = WORD_W'(SUM_W'(speed_const) / avg);
    period_acc = '0;
    edge_cnt   = '0;
    rec.speed = held_speed;
    rec.cause = CAUSE_MEASURE;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    speed_rec_t rec;
    speed_rec_t want;
    if (rst) begin
      errors      = 0;
      threshold   = THRESHOLD_RESET;
      speed_const = SPEED_CONST_RESET;
      period_acc  = '0;
      edge_cnt    = '0;
      held_speed  = '0;
      expected_speeds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SUM_THRESHOLD:  threshold   = cfg_data;
          REG_SPEED_CONSTANT: speed_const = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_speeds.size() == 0) begin
          $error("unexpected result transaction: speed=%0d cause=%0d", speed, cause);
          errors++;
        end else begin
          want = expected_speeds.pop_front();
          if (speed !== want.speed) begin
            $error("speed: expected %0d, actual %0d", want.speed, speed);
            errors++;
          end
          if (cause !== want.cause) begin
            $error("cause: expected %0d, actual %0d", want.cause, cause);
            errors++;
          end
        end
      end
      if (push && !full) begin
        if (predict_speed(operation, period, rec)) expected_speeds.push_back(rec);
      end
    end
    pending <= expected_speeds.size();
  end

endmodule

// ===== verif/averaged_period_tachometer_test.sv =====
`timescale 1ns / 1ps

module averaged_period_tachometer_test import apt_pkg::*;;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 60;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              push      = 1'b0;
  logic              operation = OP_EDGE;
  logic [WORD_W-1:0] period    = '0;
  logic              pop       = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [WORD_W-1:0] cfg_data  = '0;
  logic              full;
  logic              empty;
  logic [WORD_W-1:0] speed;
  logic              cause;
  logic              cfg_ready;
  int                err_count;
  int                pending_count;
  int                cycle_count = 0;

  averaged_period_tachometer uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .period(period), .empty(empty), .pop(pop), .speed(speed), .cause(cause),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  speed_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .period(period), .empty(empty), .pop(pop), .speed(speed), .cause(cause),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(err_count), .pending(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall pattern switches between free-running, coin-flip and long holds.
  int pop_mode  = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode  = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(1, 60);
            pop <= (hold_left == 0);
          end
        endcase
      end
    end
  end

  task automatic send_item(input logic op, input logic [WORD_W-1:0] per);
    push      <= 1'b1;
    operation <= op;
    period    <= per;
    do @(posedge clk); while (full);
  endtask

  task automatic idle_cycles(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off input until every expected result has been popped.
  task automatic wait_results;
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [WORD_W-1:0] thr, input logic [WORD_W-1:0] k);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_SUM_THRESHOLD, thr);
    write_reg(REG_SPEED_CONSTANT, k);
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] thr, input logic [WORD_W-1:0] k,
                           input int n);
    int sent;
    int burst;
    int gap;
    logic op;
    logic [WORD_W-1:0] per;
    sent = 0;
    configure(thr, k);
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < n; b++) begin
        op = ($urandom_range(0, 9) == 0) ? OP_OVERFLOW : OP_EDGE;
        case ($urandom_range(0, 9))
          0: per = '0;
          1: per = '1;
          2, 3: per = WORD_W'($urandom);
          // small periods so several edges accumulate before a crossing
          default: per = WORD_W'($urandom_range(0, (int'(thr) >> 2) + 1));
        endcase
        send_item(op, per);
        sent++;
        if (sent == n / 2) wait_results();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) idle_cycles(gap);
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("averaged_period_tachometer_test: done, errors");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: repeat before any measurement, equality at threshold
    send_item(OP_OVERFLOW, 16'hFFFF);
    send_item(OP_EDGE, 16'h0000);
    send_item(OP_EDGE, 16'hFFFF);
    send_item(OP_OVERFLOW, 16'h0000);
    send_item(OP_EDGE, 16'd50000);
    send_item(OP_EDGE, 16'd1);
    send_item(OP_OVERFLOW, 16'h5A5A);

    // zero average, and writes to unknown indexes
    configure(16'h0000, 16'hFFFF);
    write_reg(8'd2, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    send_item(OP_EDGE, 16'h0000);
    send_item(OP_EDGE, 16'h0000);
    send_item(OP_EDGE, 16'h0000);
    send_item(OP_EDGE, 16'h0001);
    send_item(OP_EDGE, 16'h0001);
    send_item(OP_OVERFLOW, 16'h0000);

    // widest sum: two full periods against the top threshold
    configure(16'hFFFF, 16'hFFFF);
    send_item(OP_EDGE, 16'hFFFF);
    send_item(OP_EDGE, 16'hFFFF);
    send_item(OP_OVERFLOW, 16'h0000);

    // zero constant
    configure(16'd100, 16'h0000);
    send_item(OP_EDGE, 16'd200);
    send_item(OP_EDGE, 16'd60);
    send_item(OP_EDGE, 16'd60);
    send_item(OP_OVERFLOW, 16'h0000);

    run_phase(THRESHOLD_RESET, SPEED_CONST_RESET, 275);
    run_phase(WORD_W'($urandom), WORD_W'($urandom), 275);
    run_phase(16'h0000, 16'h0000, 275);
    run_phase(16'hFFFF, 16'hFFFF, 275);
    run_phase(WORD_W'($urandom_range(0, 2000)), WORD_W'($urandom), 275);
    run_phase(WORD_W'($urandom), 16'hFFFF, 275);

    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("averaged_period_tachometer_test: done, clean");
    end else begin
      $display("averaged_period_tachometer_test: done, errors");
    end
    $finish;
  end

endmodule
